/* rtl/bmqd_pkg.sv */
// shared types, constants and codes for the bounded multi-queue deque
`timescale 1ns / 1ps
`default_nettype none

package bmqd_pkg;

    // storage geometry
    localparam int NUM_QUEUES  = 32;
    localparam int QUEUE_DEPTH = 8;
    localparam int ID_WIDTH    = 16;

    localparam int QIDX_W = $clog2(NUM_QUEUES);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int QNUM_W     = 6;
    localparam int ENTRY_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 3;
    localparam int CLASSES_W  = 6;
    localparam int LIMIT_W    = 4;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 1;

    // configuration reset values
    localparam logic [CLASSES_W-1:0] CLASSES_RESET = 6'd20;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 4'd5;

    // command queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 2'd0,
        OP_TAKE = 2'd1,
        OP_LIST = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLASSES = 1'b0,
        CFG_LIMIT   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_TAKE,
        CMD_LIST,
        CMD_INVALID
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [QIDX_W-1:0]   qidx;
        logic                urgent;
        logic [ID_WIDTH-1:0] entry_id;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TAKE,
        S_LIST
    } be_state_t;

endpackage

`default_nettype wire

/* rtl/bounded_multi_queue_deque.sv */
// bank of bounded deques: add, urgent add, take and list per queue
// flow: a request beat passes the command queue and the command latch of the back end;
//   a take or list on a non-empty queue also reads the entry store before the result register loads
// throughput: the execution unit works on one command at a time and pops the next
//   only once it is back in idle; a stalled output holds it where it is
// reset: head pointers and fill counts clear at once, queue count to 20, limit to 5;
//   entry storage is not cleared
`timescale 1ns / 1ps
`default_nettype none

module bounded_multi_queue_deque (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bmqd_pkg::OP_W-1:0]         op,
    input  wire logic [bmqd_pkg::QNUM_W-1:0]       queue_num,
    input  wire logic                              urgent,
    input  wire logic [bmqd_pkg::ENTRY_W-1:0]      entry_id,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [bmqd_pkg::STATUS_W-1:0]          status,
    output logic [bmqd_pkg::ENTRY_W-1:0]           entry_out,
    output logic [bmqd_pkg::POS_W-1:0]             position,
    output logic                                   last,
    input  wire logic                              cfg_we,
    input  wire logic [bmqd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bmqd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bmqd_pkg::*;

    logic [CLASSES_W-1:0] classes_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    logic fifo_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t pop_cmd;
    logic fifo_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            classes_reg <= CLASSES_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CLASSES: classes_reg <= CLASSES_W'(cfg_data);
                CFG_LIMIT:   limit_reg   <= LIMIT_W'(cfg_data);
                default:     classes_reg <= classes_reg;
            endcase
        end
    end

    // request classification
    bmqd_front u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .queue_num      (queue_num),
        .urgent         (urgent),
        .entry_id       (entry_id),
        .classes_in_use (classes_reg),
        .fifo_full      (fifo_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // decoupling queue
    bmqd_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (fifo_full),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .not_empty (fifo_valid)
    );

    // execution
    bmqd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_valid  (fifo_valid),
        .fifo_cmd    (pop_cmd),
        .pop         (pop),
        .queue_limit (limit_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_out   (entry_out),
        .position    (position),
        .last        (last)
    );

endmodule

`default_nettype wire

/* rtl/bmqd_front.sv */
// front end: takes request beats, classifies them and feeds the command queue
`timescale 1ns / 1ps
`default_nettype none

module bmqd_front (
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [bmqd_pkg::OP_W-1:0]       op,
    input  wire logic [bmqd_pkg::QNUM_W-1:0]     queue_num,
    input  wire logic                            urgent,
    input  wire logic [bmqd_pkg::ENTRY_W-1:0]    entry_id,
    input  wire logic [bmqd_pkg::CLASSES_W-1:0]  classes_in_use,
    input  wire logic                            fifo_full,
    output logic                                 push,
    output bmqd_pkg::cmd_t                       push_cmd
);
    import bmqd_pkg::*;

    logic qn_bad;

    // stall only while the command queue has no room
    assign in_stall = fifo_full;

    // op code three is swallowed without a command
    assign push = in_valid && !fifo_full && (op_t'(op) != OP_NONE);

    // queue number range check against the configured count and the bank size
    assign qn_bad = (queue_num == '0)
                 || (32'(queue_num) > 32'(classes_in_use))
                 || (32'(queue_num) > NUM_QUEUES);

    // build the command
    always_comb
    begin
        push_cmd.qidx     = QIDX_W'(32'(queue_num) - 32'd1);
        push_cmd.urgent   = urgent;
        push_cmd.entry_id = ID_WIDTH'(entry_id);
        if (qn_bad)
        begin
            push_cmd.kind = CMD_INVALID;
        end
        else
        begin
            unique case (op_t'(op))
                OP_ADD:  push_cmd.kind = CMD_ADD;
                OP_TAKE: push_cmd.kind = CMD_TAKE;
                OP_LIST: push_cmd.kind = CMD_LIST;
                default: push_cmd.kind = CMD_INVALID;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/bmqd_cmd_fifo.sv */
// short command queue between the front end and the execution back end
`timescale 1ns / 1ps
`default_nettype none

module bmqd_cmd_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  bmqd_pkg::cmd_t       push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output bmqd_pkg::cmd_t       pop_cmd,
    output logic                 not_empty
);
    import bmqd_pkg::*;

    cmd_t              slot_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg;
    logic [FPTR_W-1:0] wr_ptr_next;
    logic [FPTR_W-1:0] rd_ptr_reg;
    logic [FPTR_W-1:0] rd_ptr_next;
    logic [FCNT_W-1:0] count_reg;
    logic [FCNT_W-1:0] count_next;

    assign full      = (32'(count_reg) == FIFO_DEPTH);
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == FIFO_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == FIFO_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // command slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/bmqd_back.sv */
// back end: executes queued commands against the entry store and emits results
`timescale 1ns / 1ps
`default_nettype none

module bmqd_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           fifo_valid,
    input  bmqd_pkg::cmd_t                      fifo_cmd,
    output logic                                pop,
    input  wire logic [bmqd_pkg::LIMIT_W-1:0]   queue_limit,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [bmqd_pkg::STATUS_W-1:0]       status,
    output logic [bmqd_pkg::ENTRY_W-1:0]        entry_out,
    output logic [bmqd_pkg::POS_W-1:0]          position,
    output logic                                last
);
    import bmqd_pkg::*;

    // entry store, one row of QUEUE_DEPTH words per queue
    logic [ID_WIDTH-1:0] mem [NUM_QUEUES * QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] rdata_reg;

    // per-queue head pointer and fill count
    logic [PTR_W-1:0] head_reg [NUM_QUEUES];
    logic [CNT_W-1:0] cnt_reg  [NUM_QUEUES];

    be_state_t        state_reg;
    be_state_t        state_next;
    cmd_t             cmd_reg;
    logic [PTR_W-1:0] h_reg;
    logic [CNT_W-1:0] n_reg;
    logic [PTR_W-1:0] idx_reg;
    logic [PTR_W-1:0] idx_next;
    logic [PTR_W-1:0] lptr_reg;
    logic [PTR_W-1:0] lptr_next;

    logic                out_valid_reg;
    status_t             status_reg;
    logic [ID_WIDTH-1:0] entry_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                last_reg;

    logic                slot_free;
    logic [CNT_W-1:0]    lim;
    logic                is_full;
    logic                is_empty;
    logic                list_last;
    logic [PTR_W-1:0]    tail_ptr;
    logic [PTR_W-1:0]    head_dec;
    logic [PTR_W-1:0]    head_inc;
    logic [CNT_W:0]      tail_sum;

    logic                emit;
    status_t             emit_status;
    logic [ID_WIDTH-1:0] emit_entry;
    logic [POS_W-1:0]    emit_pos;
    logic                emit_last;
    logic                mem_we;
    logic [ADDR_W-1:0]   waddr;
    logic                mem_re;
    logic [ADDR_W-1:0]   raddr;
    logic                upd_en;
    logic [PTR_W-1:0]    upd_head;
    logic [CNT_W-1:0]    upd_cnt;

    function automatic logic [ADDR_W-1:0] row_addr(input logic [QIDX_W-1:0] q,
                                                   input logic [PTR_W-1:0] p);
        return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    // output register frees up when empty or being taken
    assign slot_free = !out_valid_reg || !out_stall;

    // effective limit and per-command conditions
    assign lim       = (32'(queue_limit) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH)
                                                        : CNT_W'(queue_limit);
    assign is_full   = (n_reg >= lim);
    assign is_empty  = (n_reg == '0);
    assign list_last = ((32'(idx_reg) + 32'd1) == 32'(n_reg));

    // ring arithmetic on the head pointer
    assign tail_sum = (CNT_W + 1)'(h_reg) + (CNT_W + 1)'(n_reg);
    assign tail_ptr = (32'(tail_sum) >= QUEUE_DEPTH)
                    ? PTR_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH))
                    : PTR_W'(tail_sum);
    assign head_dec = (h_reg == '0) ? PTR_W'(QUEUE_DEPTH - 1) : h_reg - 1'b1;
    assign head_inc = ptr_inc(h_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fifo_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cmd_reg.kind)
                    CMD_INVALID, CMD_ADD:
                    begin
                        if (slot_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    CMD_TAKE, CMD_LIST:
                    begin
                        if (!is_empty)
                        begin
                            state_next = (cmd_reg.kind == CMD_TAKE) ? S_TAKE : S_LIST;
                        end
                        else if (slot_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_TAKE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (slot_free && list_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        pop         = 1'b0;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_entry  = '0;
        emit_pos    = '0;
        emit_last   = 1'b1;
        mem_we      = 1'b0;
        waddr       = row_addr(cmd_reg.qidx, tail_ptr);
        mem_re      = 1'b0;
        raddr       = row_addr(cmd_reg.qidx, h_reg);
        upd_en      = 1'b0;
        upd_head    = h_reg;
        upd_cnt     = n_reg;
        idx_next    = idx_reg;
        lptr_next   = lptr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                pop = fifo_valid;
            end
            S_EXEC:
            begin
                unique case (cmd_reg.kind)
                    CMD_INVALID:
                    begin
                        emit        = slot_free;
                        emit_status = ST_INVALID;
                    end
                    CMD_ADD:
                    begin
                        emit = slot_free;
                        if (is_full)
                        begin
                            emit_status = ST_FULL;
                        end
                        else
                        begin
                            emit_status = ST_OK;
                            mem_we      = slot_free;
                            upd_en      = slot_free;
                            upd_cnt     = n_reg + 1'b1;
                            if (cmd_reg.urgent)
                            begin
                                waddr    = row_addr(cmd_reg.qidx, head_dec);
                                upd_head = head_dec;
                            end
                        end
                    end
                    CMD_TAKE, CMD_LIST:
                    begin
                        if (is_empty)
                        begin
                            emit        = slot_free;
                            emit_status = ST_EMPTY;
                        end
                        else
                        begin
                            mem_re    = 1'b1;
                            idx_next  = '0;
                            lptr_next = head_inc;
                        end
                    end
                    default: emit = 1'b0;
                endcase
            end
            S_TAKE:
            begin
                emit        = slot_free;
                emit_status = ST_OK;
                emit_entry  = rdata_reg;
                upd_en      = slot_free;
                upd_head    = head_inc;
                upd_cnt     = n_reg - 1'b1;
            end
            S_LIST:
            begin
                emit        = slot_free;
                emit_status = ST_OK;
                emit_entry  = rdata_reg;
                emit_pos    = POS_W'(idx_reg);
                emit_last   = list_last;
                if (slot_free && !list_last)
                begin
                    mem_re    = 1'b1;
                    raddr     = row_addr(cmd_reg.qidx, lptr_reg);
                    lptr_next = ptr_inc(lptr_reg);
                    idx_next  = idx_reg + 1'b1;
                end
            end
            default: pop = 1'b0;
        endcase
    end

    // control state and queue bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (upd_en)
            begin
                head_reg[cmd_reg.qidx] <= upd_head;
                cnt_reg[cmd_reg.qidx]  <= upd_cnt;
            end
        end
    end

    // command latch and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= fifo_cmd;
            h_reg   <= head_reg[fifo_cmd.qidx];
            n_reg   <= cnt_reg[fifo_cmd.qidx];
        end
        idx_reg  <= idx_next;
        lptr_reg <= lptr_next;
        if (emit)
        begin
            status_reg <= emit_status;
            entry_reg  <= emit_entry;
            pos_reg    <= emit_pos;
            last_reg   <= emit_last;
        end
    end

    // entry store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= cmd_reg.entry_id;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign entry_out = ENTRY_W'(entry_reg);
    assign position  = pos_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire
